// ----- hw/rtl/fsa_pkg.sv -----
package fsa_pkg;

    localparam int MEMORY_DEPTH = 4096;
    localparam int MAX_SEGMENTS = 64;
    localparam int ADDR_W       = $clog2(MEMORY_DEPTH);
    localparam int LEN_W        = 13;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int OWNER_W      = 32;
    localparam int CFG_AW       = 3;

    typedef enum logic [2:0] {
        OP_ALLOC  = 3'd0,
        OP_FREE   = 3'd1,
        OP_READ   = 3'd2,
        OP_WRITE  = 3'd3,
        OP_PREAD  = 3'd4,
        OP_PWRITE = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        STS_OK         = 3'd0,
        STS_NO_FIT     = 3'd1,
        STS_UNKNOWN_ID = 3'd2,
        STS_OFFSET_OUT = 3'd3,
        STS_ADDR_OUT   = 3'd4,
        STS_TABLE_FULL = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2
    } t_strategy;

    typedef enum logic [0:0] {
        REG_STRATEGY  = 1'b0,
        REG_MEM_WORDS = 1'b1
    } t_reg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_NB_RD,
        ST_NB_WAIT,
        ST_WR_F,
        ST_SHIFT,
        ST_WR_A,
        ST_WR_B,
        ST_DATA,
        ST_DATA_WAIT
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0]  start;
        logic [LEN_W-1:0]   len;
        logic               is_free;
        logic [OWNER_W-1:0] owner;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [2:0]         operation;
        logic [15:0]        request_size;
        logic [31:0]        owner_id;
        logic [15:0]        offset;
        logic [15:0]        address;
        logic signed [31:0] write_value;
    } t_request;

    typedef struct packed {
        logic [2:0]         status;
        logic [31:0]        granted_id;
        logic signed [31:0] read_value;
    } t_response;

    typedef struct packed {
        logic               clear;
        logic               valid;
        logic               lookup;
        logic [1:0]         strategy;
        logic [15:0]        size;
        logic [OWNER_W-1:0] id;
        logic [IDX_W-1:0]   idx;
    } t_fit_ctl;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
        t_entry           pick;
        logic [LEN_W-1:0] rem;
        t_entry           prev;
    } t_fit_res;

endpackage

// ----- hw/rtl/fsa_ram.sv -----
module fsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/fsa_fit_unit.sv -----
module fsa_fit_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fsa_pkg::t_fit_ctl i_ctl,
    input  fsa_pkg::t_entry   i_entry,
    output fsa_pkg::t_fit_res o_res
);
    import fsa_pkg::*;

    logic             r_found;
    logic [IDX_W-1:0] r_idx;
    t_entry           r_pick;
    logic [LEN_W-1:0] r_rem;
    t_entry           r_prev;

    logic             eligible;
    logic [LEN_W-1:0] rem;
    logic             take;

    // one subtract and compare per table entry
    always_comb begin
        eligible = i_entry.is_free
                && ({{(16-LEN_W){1'b0}}, i_entry.len} >= i_ctl.size);
        rem      = i_entry.len - i_ctl.size[LEN_W-1:0];
        take     = 1'b0;
        if (i_ctl.lookup) begin
            take = !r_found && !i_entry.is_free && (i_entry.owner == i_ctl.id)
                && (i_ctl.id != '0);
        end else begin
            case (i_ctl.strategy)
                FIT_FIRST: take = eligible && !r_found;
                FIT_BEST:  take = eligible && (!r_found || rem < r_rem);
                FIT_WORST: take = eligible && (!r_found || rem > r_rem);
                default:   take = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (i_ctl.valid && take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_ctl.clear && i_ctl.valid) begin
            if (take) begin
                r_idx  <= i_ctl.idx;
                r_pick <= i_entry;
                r_rem  <= rem;
            end else if (i_ctl.lookup && !r_found) begin
                // entry just below the match, needed for merging on free
                r_prev <= i_entry;
            end
        end
    end

    assign o_res = '{found: r_found, idx: r_idx, pick: r_pick, rem: r_rem, prev: r_prev};

    a_clear_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clear |=> !r_found)
        else $error("found flag survived a clear");

    a_found_sticky_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_found && !i_ctl.clear && i_ctl.lookup) |=> r_found)
        else $error("lookup match lost");

    a_lookup_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.valid && !i_ctl.clear && i_ctl.lookup && take)
            |=> (r_pick.owner == $past(i_ctl.id)) && !r_pick.is_free)
        else $error("lookup picked a wrong entry");

endmodule

// ----- hw/rtl/fit_strategy_segment_allocator.sv -----
// timing: allocate and id lookups walk the segment table one entry per cycle, then
//   table entries are moved one by one on a split or merge; physical accesses go
//   straight to the data memory read or write, unused codes are answered from idle
// throughput: one item at a time, busy is high until the result strobe; the table
//   memory read port sets the pace; the receiver cannot stall, each result is one beat
// reset: a clearing pass zeroes the 4096-word data memory, then the table is set
//   up; busy stays high meanwhile, configuration writes are taken
module fit_strategy_segment_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fsa_pkg::CFG_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        start,
    output logic                        busy,
    input  fsa_pkg::t_request           i_req,
    output logic                        o_done,
    output fsa_pkg::t_response          o_rsp
);
    import fsa_pkg::*;

    t_state             r_state, n_state;
    logic               r_tbl_init, n_tbl_init;
    logic [ADDR_W-1:0]  r_clr, n_clr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [OWNER_W-1:0] r_next_id, n_next_id;
    logic [1:0]         r_strategy, n_strategy;
    logic [LEN_W-1:0]   r_mem_words, n_mem_words;
    logic               r_done, n_done;
    logic [CNT_W-1:0]   r_ka, n_ka;
    logic               r_dv, n_dv;
    logic               r_wv, n_wv;

    t_request           r_req, n_req;
    logic [IDX_W-1:0]   r_kd, n_kd;
    t_entry             r_nb, n_nb;
    logic               r_nb_ok, n_nb_ok;
    logic [CNT_W-1:0]   r_dst, n_dst;
    logic               r_up, n_up;
    logic [1:0]         r_dist, n_dist;
    logic [IDX_W-1:0]   r_wa, n_wa;
    logic [ADDR_W-1:0]  r_phys, n_phys;
    t_response          r_rsp, n_rsp;

    logic               tbl_we, tbl_re;
    logic [IDX_W-1:0]   tbl_wa, tbl_ra;
    t_entry             tbl_wd, tbl_rd;
    logic               dat_we, dat_re;
    logic [ADDR_W-1:0]  dat_wa, dat_ra;
    logic [31:0]        dat_wd, dat_rd;

    t_fit_ctl           fit_ctl;
    t_fit_res           fit_res;

    logic               cfg_wr;
    logic               accept;

    assign cfg_wr = psel && penable && pwrite;
    assign busy   = (r_state != ST_IDLE) || r_tbl_init;
    assign accept = start && !busy;
    assign pready = 1'b1;

    always_comb begin
        unique case (t_reg'(paddr[2]))
            REG_STRATEGY:  prdata = {30'd0, r_strategy};
            REG_MEM_WORDS: prdata = {{(32-LEN_W){1'b0}}, r_mem_words};
            default:       prdata = '0;
        endcase
    end

    fsa_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SEGMENTS)) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_we),
        .i_wr_addr (tbl_wa),
        .i_wr_data (tbl_wd),
        .i_rd_en   (tbl_re),
        .i_rd_addr (tbl_ra),
        .o_rd_data (tbl_rd)
    );

    fsa_ram #(.WIDTH(32), .DEPTH(MEMORY_DEPTH)) u_data (
        .i_clk     (i_clk),
        .i_wr_en   (dat_we),
        .i_wr_addr (dat_wa),
        .i_wr_data (dat_wd),
        .i_rd_en   (dat_re),
        .i_rd_addr (dat_ra),
        .o_rd_data (dat_rd)
    );

    fsa_fit_unit u_fit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (fit_ctl),
        .i_entry (tbl_rd),
        .o_res   (fit_res)
    );

    always_comb begin
        logic [LEN_W-1:0]  wr_words;
        logic              issue;
        logic [CNT_W-1:0]  pick1;
        logic [CNT_W-1:0]  src;
        logic              nf, pf;
        logic [IDX_W-1:0]  base;
        logic [LEN_W-1:0]  sum;
        logic [LEN_W-1:0]  phys;

        n_state     = r_state;
        n_tbl_init  = r_tbl_init;
        n_clr       = r_clr;
        n_count     = r_count;
        n_next_id   = r_next_id;
        n_strategy  = r_strategy;
        n_mem_words = r_mem_words;
        n_done      = 1'b0;
        n_ka        = r_ka;
        n_dv        = 1'b0;
        n_wv        = 1'b0;
        n_req       = r_req;
        n_kd        = r_kd;
        n_nb        = r_nb;
        n_nb_ok     = r_nb_ok;
        n_dst       = r_dst;
        n_up        = r_up;
        n_dist      = r_dist;
        n_wa        = r_wa;
        n_phys      = r_phys;
        n_rsp       = r_rsp;

        tbl_we = 1'b0;
        tbl_wa = '0;
        tbl_wd = '0;
        tbl_re = 1'b0;
        tbl_ra = '0;
        dat_we = 1'b0;
        dat_wa = r_clr;
        dat_wd = '0;
        dat_re = 1'b0;
        dat_ra = r_phys;

        fit_ctl          = '0;
        fit_ctl.lookup   = (r_req.operation != OP_ALLOC);
        fit_ctl.strategy = r_strategy;
        fit_ctl.size     = r_req.request_size;
        fit_ctl.id       = r_req.owner_id;
        fit_ctl.idx      = r_kd;

        pick1  = CNT_W'({1'b0, fit_res.idx}) + CNT_W'(1);
        issue  = 1'b0;
        src    = '0;
        nf     = r_nb_ok && r_nb.is_free;
        pf     = (fit_res.idx != '0) && fit_res.prev.is_free;
        base   = pf ? fit_res.idx - IDX_W'(1) : fit_res.idx;
        sum    = fit_res.pick.len + (nf ? r_nb.len : '0) + (pf ? fit_res.prev.len : '0);
        phys   = {1'b0, fit_res.pick.start} + r_req.offset[LEN_W-1:0];

        wr_words = pwdata[LEN_W-1:0];
        if (wr_words == '0) begin
            wr_words = LEN_W'(1);
        end else if (wr_words > LEN_W'(MEMORY_DEPTH)) begin
            wr_words = LEN_W'(MEMORY_DEPTH);
        end

        unique case (r_state)
            ST_CLEAR: begin
                dat_we = 1'b1;
                n_clr  = r_clr + ADDR_W'(1);
                if (r_clr == '1) begin
                    n_state = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (r_tbl_init) begin
                    tbl_we     = 1'b1;
                    tbl_wa     = '0;
                    tbl_wd     = '{start: '0, len: r_mem_words, is_free: 1'b1, owner: '0};
                    n_tbl_init = 1'b0;
                end else if (accept) begin
                    n_req = i_req;
                    case (i_req.operation)
                        OP_ALLOC, OP_FREE, OP_READ, OP_WRITE: begin
                            fit_ctl.clear = 1'b1;
                            n_ka          = '0;
                            n_state       = ST_SCAN;
                        end
                        OP_PREAD, OP_PWRITE: begin
                            if (i_req.address >= {{(16-LEN_W){1'b0}}, r_mem_words}) begin
                                n_done     = 1'b1;
                                n_rsp      = '0;
                                n_rsp.status = STS_ADDR_OUT;
                            end else begin
                                n_phys  = i_req.address[ADDR_W-1:0];
                                n_state = ST_DATA;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                            n_rsp  = '0;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                fit_ctl.valid = r_dv;
                issue         = r_ka < r_count;
                if (issue) begin
                    tbl_re = 1'b1;
                    tbl_ra = r_ka[IDX_W-1:0];
                    n_ka   = r_ka + CNT_W'(1);
                    n_kd   = r_ka[IDX_W-1:0];
                    n_dv   = 1'b1;
                end
                if ((fit_ctl.lookup && fit_res.found) || (!issue && !r_dv)) begin
                    n_dv    = 1'b0;
                    n_state = ST_DECIDE;
                end
            end

            ST_DECIDE: begin
                case (r_req.operation)
                    OP_ALLOC: begin
                        if (r_req.request_size == '0 || !fit_res.found) begin
                            n_done       = 1'b1;
                            n_rsp        = '0;
                            n_rsp.status = STS_NO_FIT;
                            n_state      = ST_IDLE;
                        end else if (fit_res.rem == '0) begin
                            n_state = ST_WR_B;
                        end else if (r_count >= CNT_W'(MAX_SEGMENTS)) begin
                            n_done       = 1'b1;
                            n_rsp        = '0;
                            n_rsp.status = STS_TABLE_FULL;
                            n_state      = ST_IDLE;
                        end else begin
                            // open a hole right after the pick
                            n_dst   = r_count;
                            n_up    = 1'b1;
                            n_dist  = 2'd1;
                            n_state = ST_SHIFT;
                        end
                    end
                    OP_FREE: begin
                        if (!fit_res.found) begin
                            n_done       = 1'b1;
                            n_rsp        = '0;
                            n_rsp.status = STS_UNKNOWN_ID;
                            n_state      = ST_IDLE;
                        end else begin
                            n_nb_ok = pick1 < r_count;
                            n_state = (pick1 < r_count) ? ST_NB_RD : ST_WR_F;
                        end
                    end
                    default: begin
                        n_rsp = '0;
                        if (!fit_res.found) begin
                            n_done       = 1'b1;
                            n_rsp.status = STS_UNKNOWN_ID;
                            n_state      = ST_IDLE;
                        end else if (r_req.offset >= {{(16-LEN_W){1'b0}}, fit_res.pick.len}) begin
                            n_done       = 1'b1;
                            n_rsp.status = STS_OFFSET_OUT;
                            n_state      = ST_IDLE;
                        end else if (phys >= LEN_W'(MEMORY_DEPTH)) begin
                            n_done       = 1'b1;
                            n_rsp.status = STS_ADDR_OUT;
                            n_state      = ST_IDLE;
                        end else begin
                            n_phys  = phys[ADDR_W-1:0];
                            n_state = ST_DATA;
                        end
                    end
                endcase
            end

            ST_NB_RD: begin
                tbl_re  = 1'b1;
                tbl_ra  = pick1[IDX_W-1:0];
                n_state = ST_NB_WAIT;
            end

            ST_NB_WAIT: begin
                n_nb    = tbl_rd;
                n_state = ST_WR_F;
            end

            ST_WR_F: begin
                tbl_we = 1'b1;
                tbl_wa = base;
                tbl_wd = '{start: pf ? fit_res.prev.start : fit_res.pick.start,
                           len: sum, is_free: 1'b1, owner: '0};
                if (!nf && !pf) begin
                    n_done  = 1'b1;
                    n_rsp   = '0;
                    n_state = ST_IDLE;
                end else begin
                    // close the gap left by the merged neighbors
                    n_dst   = CNT_W'({1'b0, base}) + CNT_W'(1);
                    n_up    = 1'b0;
                    n_dist  = {nf && pf, nf ^ pf};
                    n_state = ST_SHIFT;
                end
            end

            ST_SHIFT: begin
                if (r_up) begin
                    issue = r_dst > pick1;
                    src   = r_dst - CNT_W'(1);
                end else begin
                    issue = (r_dst + CNT_W'(r_dist)) < r_count;
                    src   = r_dst + CNT_W'(r_dist);
                end
                tbl_we = r_wv;
                tbl_wa = r_wa;
                tbl_wd = tbl_rd;
                if (issue) begin
                    tbl_re = 1'b1;
                    tbl_ra = src[IDX_W-1:0];
                    n_wv   = 1'b1;
                    n_wa   = r_dst[IDX_W-1:0];
                    n_dst  = r_up ? r_dst - CNT_W'(1) : r_dst + CNT_W'(1);
                end else if (!r_wv) begin
                    if (r_up) begin
                        n_state = ST_WR_A;
                    end else begin
                        n_count = r_count - CNT_W'(r_dist);
                        n_done  = 1'b1;
                        n_rsp   = '0;
                        n_state = ST_IDLE;
                    end
                end
            end

            ST_WR_A: begin
                tbl_we  = 1'b1;
                tbl_wa  = pick1[IDX_W-1:0];
                tbl_wd  = '{start: fit_res.pick.start + r_req.request_size[ADDR_W-1:0],
                            len: fit_res.rem, is_free: 1'b1, owner: '0};
                n_count = r_count + CNT_W'(1);
                n_state = ST_WR_B;
            end

            ST_WR_B: begin
                tbl_we    = 1'b1;
                tbl_wa    = fit_res.idx;
                tbl_wd    = '{start: fit_res.pick.start, len: r_req.request_size[LEN_W-1:0],
                              is_free: 1'b0, owner: r_next_id};
                n_done    = 1'b1;
                n_rsp     = '0;
                n_rsp.granted_id = r_next_id;
                n_next_id = (r_next_id == '1) ? OWNER_W'(1) : r_next_id + OWNER_W'(1);
                n_state   = ST_IDLE;
            end

            ST_DATA: begin
                if (r_req.operation == OP_WRITE || r_req.operation == OP_PWRITE) begin
                    dat_we  = 1'b1;
                    dat_wa  = r_phys;
                    dat_wd  = r_req.write_value;
                    n_done  = 1'b1;
                    n_rsp   = '0;
                    n_state = ST_IDLE;
                end else begin
                    dat_re  = 1'b1;
                    n_state = ST_DATA_WAIT;
                end
            end

            ST_DATA_WAIT: begin
                n_done           = 1'b1;
                n_rsp            = '0;
                n_rsp.read_value = dat_rd;
                n_state          = ST_IDLE;
            end

            default: n_state = ST_IDLE;
        endcase

        if (cfg_wr) begin
            unique case (t_reg'(paddr[2]))
                REG_STRATEGY:  n_strategy = pwdata[1:0];
                REG_MEM_WORDS: begin
                    n_mem_words = wr_words;
                    n_tbl_init  = 1'b1;
                    n_count     = CNT_W'(1);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_tbl_init  <= 1'b1;
            r_clr       <= '0;
            r_count     <= CNT_W'(1);
            r_next_id   <= OWNER_W'(1);
            r_strategy  <= FIT_FIRST;
            r_mem_words <= LEN_W'(MEMORY_DEPTH);
            r_done      <= 1'b0;
            r_ka        <= '0;
            r_dv        <= 1'b0;
            r_wv        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tbl_init  <= n_tbl_init;
            r_clr       <= n_clr;
            r_count     <= n_count;
            r_next_id   <= n_next_id;
            r_strategy  <= n_strategy;
            r_mem_words <= n_mem_words;
            r_done      <= n_done;
            r_ka        <= n_ka;
            r_dv        <= n_dv;
            r_wv        <= n_wv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_kd    <= n_kd;
        r_nb    <= n_nb;
        r_nb_ok <= n_nb_ok;
        r_dst   <= n_dst;
        r_up    <= n_up;
        r_dist  <= n_dist;
        r_wa    <= n_wa;
        r_phys  <= n_phys;
        r_rsp   <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// ----- tb/sv/fsa_checker.sv -----
`timescale 1ns / 100ps

module fsa_checker
    import fsa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [CFG_AW-1:0]  i_paddr,
    input  logic [31:0]        i_pwdata,
    input  logic               i_pready,
    input  logic               i_start,
    input  logic               i_busy,
    input  t_request           i_req,
    input  logic               i_done,
    input  t_response          i_rsp,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_results
);

    // shadow of the allocator state
    int unsigned seg_start [MAX_SEGMENTS];
    int unsigned seg_len   [MAX_SEGMENTS];
    bit          seg_free  [MAX_SEGMENTS];
    int unsigned seg_owner [MAX_SEGMENTS];
    int unsigned seg_count;
    int unsigned next_id;
    int unsigned mem_image [MEMORY_DEPTH];
    int unsigned strategy;
    int unsigned mem_words;

    t_response expected_rsp [$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h", $realtime, what, got,
                 want);
        o_errors++;
    endtask

    function automatic void clear_table();
        for (int k = 0; k < MAX_SEGMENTS; k++) begin
            seg_start[k] = 0;
            seg_len[k]   = 0;
            seg_free[k]  = 0;
            seg_owner[k] = 0;
        end
        seg_len[0]  = mem_words;
        seg_free[0] = 1;
        seg_count   = 1;
    endfunction

    function automatic void drop_entry(int unsigned k);
        for (int unsigned j = k; j + 1 < seg_count; j++) begin
            seg_start[j] = seg_start[j+1];
            seg_len[j]   = seg_len[j+1];
            seg_free[j]  = seg_free[j+1];
            seg_owner[j] = seg_owner[j+1];
        end
        seg_count--;
    endfunction

    function automatic int unsigned owner_index(int unsigned id);
        if (id == 0) return seg_count;
        for (int unsigned k = 0; k < seg_count; k++)
            if (!seg_free[k] && seg_owner[k] == id) return k;
        return seg_count;
    endfunction

    function automatic t_response predict_response(t_request r);
        t_response   rsp;
        int unsigned pick, rem, k, phys;
        bit          found;
        rsp = '0;
        found = 0;
        pick = 0;
        rem = 0;
        case (r.operation)
            OP_ALLOC: begin
                if (r.request_size == 0) begin
                    rsp.status = STS_NO_FIT;
                end else begin
                    for (k = 0; k < seg_count; k++) begin
                        if (!seg_free[k] || seg_len[k] < r.request_size) continue;
                        if (strategy == FIT_FIRST) begin
                            if (!found) begin
                                found = 1; pick = k; rem = seg_len[k] - r.request_size;
                            end
                        end else if (strategy == FIT_BEST) begin
                            if (!found || seg_len[k] - r.request_size < rem) begin
                                found = 1; pick = k; rem = seg_len[k] - r.request_size;
                            end
                        end else if (strategy == FIT_WORST) begin
                            if (!found || seg_len[k] - r.request_size > rem) begin
                                found = 1; pick = k; rem = seg_len[k] - r.request_size;
                            end
                        end
                    end
                    if (!found) begin
                        rsp.status = STS_NO_FIT;
                    end else if (rem > 0 && seg_count >= MAX_SEGMENTS) begin
                        rsp.status = STS_TABLE_FULL;
                    end else begin
                        if (rem > 0) begin
                            for (k = seg_count; k > pick + 1; k--) begin
                                seg_start[k] = seg_start[k-1];
                                seg_len[k]   = seg_len[k-1];
                                seg_free[k]  = seg_free[k-1];
                                seg_owner[k] = seg_owner[k-1];
                            end
                            seg_start[pick+1] = seg_start[pick] + r.request_size;
                            seg_len[pick+1]   = rem;
                            seg_free[pick+1]  = 1;
                            seg_owner[pick+1] = 0;
                            seg_count++;
                        end
                        seg_len[pick]   = r.request_size;
                        seg_free[pick]  = 0;
                        seg_owner[pick] = next_id;
                        rsp.granted_id  = next_id;
                        next_id++;
                        if (next_id == 0) next_id = 1;
                    end
                end
            end
            OP_FREE: begin
                k = owner_index(r.owner_id);
                if (k >= seg_count) begin
                    rsp.status = STS_UNKNOWN_ID;
                end else begin
                    seg_free[k]  = 1;
                    seg_owner[k] = 0;
                    if (k + 1 < seg_count && seg_free[k+1]) begin
                        seg_len[k] += seg_len[k+1];
                        drop_entry(k + 1);
                    end
                    if (k > 0 && seg_free[k-1]) begin
                        seg_len[k-1] += seg_len[k];
                        drop_entry(k);
                    end
                end
            end
            OP_READ, OP_WRITE: begin
                k = owner_index(r.owner_id);
                if (k >= seg_count) begin
                    rsp.status = STS_UNKNOWN_ID;
                end else if (r.offset >= seg_len[k]) begin
                    rsp.status = STS_OFFSET_OUT;
                end else begin
                    phys = seg_start[k] + r.offset;
                    if (phys >= MEMORY_DEPTH) rsp.status = STS_ADDR_OUT;
                    else if (r.operation == OP_READ) rsp.read_value = mem_image[phys];
                    else mem_image[phys] = r.write_value;
                end
            end
            OP_PREAD, OP_PWRITE: begin
                if (r.address >= mem_words || r.address >= MEMORY_DEPTH)
                    rsp.status = STS_ADDR_OUT;
                else if (r.operation == OP_PREAD) rsp.read_value = mem_image[r.address];
                else mem_image[r.address] = r.write_value;
            end
            default: ;
        endcase
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_response want;
        int unsigned v;
        if (!i_rst_n) begin
            o_errors  = 0;
            o_results = 0;
            strategy  = FIT_FIRST;
            mem_words = MEMORY_DEPTH;
            next_id   = 1;
            for (int k = 0; k < MEMORY_DEPTH; k++) mem_image[k] = 0;
            clear_table();
            expected_rsp.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[CFG_AW-1:2] == REG_STRATEGY) begin
                    strategy = i_pwdata & 32'h3;
                end else if (i_paddr[CFG_AW-1:2] == REG_MEM_WORDS) begin
                    v = i_pwdata & 32'h1FFF;
                    if (v == 0) v = 1;
                    if (v > MEMORY_DEPTH) v = MEMORY_DEPTH;
                    mem_words = v;
                    clear_table();
                end
            end
            if (i_done) begin
                o_results++;
                if (expected_rsp.size() == 0) begin
                    report_mismatch("result beat with nothing expected", 32'd1, 32'd0);
                end else begin
                    want = expected_rsp.pop_front();
                    if (i_rsp.status !== want.status)
                        report_mismatch("status", 32'(i_rsp.status), 32'(want.status));
                    if (i_rsp.granted_id !== want.granted_id)
                        report_mismatch("granted_id", i_rsp.granted_id, want.granted_id);
                    if (i_rsp.read_value !== want.read_value)
                        report_mismatch("read_value", i_rsp.read_value, want.read_value);
                end
            end
            if (i_start && !i_busy)
                expected_rsp.insert(expected_rsp.size(), predict_response(i_req));
        end
        o_pending = expected_rsp.size();
    end

endmodule

// ----- tb/sv/tb_fit_strategy_segment_allocator.sv -----
`timescale 1ns / 100ps

module tb_fit_strategy_segment_allocator;
    import fsa_pkg::*;

    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel, penable, pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              start;
    logic              busy;
    t_request          i_req;
    logic              o_done;
    t_response         o_rsp;

    int errors, pending, results;
    int items_sent;
    bit no_gaps;
    logic [31:0] live_ids [$];

    fit_strategy_segment_allocator DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy), .i_req(i_req), .o_done(o_done), .o_rsp(o_rsp)
    );

    fsa_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .i_start(start), .i_busy(busy), .i_req(i_req),
        .i_done(o_done), .i_rsp(o_rsp),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    // keep the ids that are handed out so frees and accesses hit real segments
    always @(posedge i_clk) begin
        if (i_rst_n && o_done && o_rsp.status == STS_OK && o_rsp.granted_id != 0)
            live_ids.insert(live_ids.size(), o_rsp.granted_id);
    end

    initial begin
        #20_000_000;
        $display("timeout waiting for the allocator");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_item(input t_request r);
        if (!no_gaps && $urandom_range(99) < 32) begin
            repeat ($urandom_range(1, 6)) begin
                @(negedge i_clk);
                start <= 1'b0;
            end
        end
        forever begin
            @(negedge i_clk);
            if (!busy) begin
                start <= 1'b1;
                i_req <= r;
                break;
            end
            start <= 1'b0;
        end
        items_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg idx, input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= CFG_AW'(idx) << 2; pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    function automatic t_request make_req(logic [2:0] op, logic [15:0] size, logic [31:0] id,
                                          logic [15:0] off, logic [15:0] addr,
                                          logic [31:0] wval);
        t_request r;
        r.operation = op; r.request_size = size; r.owner_id = id;
        r.offset = off; r.address = addr; r.write_value = wval;
        return r;
    endfunction

    function automatic logic [31:0] pick_id(bit take);
        int n;
        logic [31:0] id;
        if (live_ids.size() == 0 || $urandom_range(9) == 0) return $urandom;
        n = $urandom_range(live_ids.size() - 1);
        id = live_ids[n];
        if (take) live_ids.delete(n);
        return id;
    endfunction

    function automatic t_request random_req(int words);
        int sel;
        t_request r;
        r = make_req(OP_ALLOC, 0, 0, 0, 0, $urandom);
        sel = $urandom_range(99);
        if (sel < 40) begin
            r.operation = OP_ALLOC;
            case ($urandom_range(19))
                0:       r.request_size = 0;
                1:       r.request_size = 16'($urandom);
                2, 3:    r.request_size = 16'($urandom_range(1, words));
                default: r.request_size = 16'($urandom_range(1, 24));
            endcase
        end else if (sel < 60) begin
            r.operation = OP_FREE;
            r.owner_id  = pick_id(1);
        end else if (sel < 85) begin
            r.operation = (sel < 72) ? OP_READ : OP_WRITE;
            r.owner_id  = pick_id(0);
            r.offset    = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 26));
        end else if (sel < 98) begin
            r.operation = (sel < 91) ? OP_PREAD : OP_PWRITE;
            r.address   = ($urandom_range(4) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, words + 2));
        end else begin
            r.operation = (sel == 98) ? OP_SPARE_LO : OP_SPARE_HI;
            r.request_size = 16'($urandom); r.owner_id = $urandom;
            r.offset = 16'($urandom); r.address = 16'($urandom);
        end
        return r;
    endfunction

    int phase_strategy [7] = '{FIT_FIRST, FIT_BEST, FIT_WORST, 3, FIT_BEST, FIT_WORST, FIT_FIRST};
    int phase_words    [7] = '{4096, 64, 200, 100, 0, 8191, 4097};

    initial begin
        int words;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        start = 1'b0; i_req = '0;
        items_sent = 0; no_gaps = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);

        // directed corners on the reset setting
        send_item(make_req(OP_ALLOC, 16'd0, 0, 0, 0, 0));
        send_item(make_req(OP_ALLOC, 16'hFFFF, 0, 0, 0, 0));
        send_item(make_req(OP_ALLOC, 16'd1, 0, 0, 0, 0));
        send_item(make_req(OP_ALLOC, 16'd10, 0, 0, 0, 0));
        send_item(make_req(OP_WRITE, 0, 32'd2, 16'd9, 0, 32'h8000_0000));
        send_item(make_req(OP_READ, 0, 32'd2, 16'd9, 0, 0));
        send_item(make_req(OP_READ, 0, 32'd2, 16'd10, 0, 0));
        send_item(make_req(OP_READ, 0, 32'd2, 16'hFFFF, 0, 0));
        send_item(make_req(OP_READ, 0, 32'd0, 0, 0, 0));
        send_item(make_req(OP_FREE, 0, 32'd0, 0, 0, 0));
        send_item(make_req(OP_FREE, 0, 32'hFFFF_FFFF, 0, 0, 0));
        send_item(make_req(OP_PWRITE, 0, 0, 0, 16'd4095, 32'h7FFF_FFFF));
        send_item(make_req(OP_PREAD, 0, 0, 0, 16'd4095, 0));
        send_item(make_req(OP_PREAD, 0, 0, 0, 16'd4096, 0));
        send_item(make_req(OP_PWRITE, 0, 0, 0, 16'hFFFF, 32'hFFFF_FFFF));
        send_item(make_req(OP_PREAD, 0, 0, 0, 16'd1, 0));
        send_item(make_req(OP_SPARE_LO, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, '1));
        send_item(make_req(OP_SPARE_HI, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, '1));
        send_item(make_req(OP_FREE, 0, 32'd1, 0, 0, 0));
        send_item(make_req(OP_FREE, 0, 32'd2, 0, 0, 0));
        send_item(make_req(OP_ALLOC, 16'd4096, 0, 0, 0, 0));
        send_item(make_req(OP_READ, 0, 32'd3, 16'd4095, 0, 0));
        send_item(make_req(OP_FREE, 0, 32'd3, 0, 0, 0));

        for (int p = 0; p < 7; p++) begin
            drain();
            write_reg(REG_STRATEGY, phase_strategy[p]);
            write_reg(REG_MEM_WORDS, phase_words[p]);
            live_ids.delete();
            words = phase_words[p] == 0 ? 1 : (phase_words[p] > 4096 ? 4096 : phase_words[p]);
            no_gaps = (p == 2);
            // fill the table with single-word segments until it runs out of entries
            if (p == 0)
                repeat (70) send_item(make_req(OP_ALLOC, 16'd1, 0, 0, 0, 0));
            repeat (250) send_item(random_req(words));
        end

        drain();
        $display("%0d items over 7 strategy and size settings, %0d results checked",
                 items_sent, results);
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- fit_strategy_segment_allocator.f -----
hw/rtl/fsa_pkg.sv
hw/rtl/fsa_ram.sv
hw/rtl/fsa_fit_unit.sv
hw/rtl/fit_strategy_segment_allocator.sv
tb/sv/fsa_checker.sv
tb/sv/tb_fit_strategy_segment_allocator.sv
